// ===== src/tbo_pkg.sv =====
package tbo_pkg;
    localparam int LANE_W = 16;
    localparam int POINT_W = 48;
    typedef logic [POINT_W-1:0] t_point;
    typedef struct packed {
        t_point vertex_a;
        t_point vertex_b;
        t_point vertex_c;
        t_point box_low_corner;
        t_point box_high_corner;
    } t_in_item;
endpackage

// ===== src/tbo_if.sv =====
interface tbo_in_if;
    logic valid;
    logic ready;
    tbo_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbo_out_if;
    logic valid;
    logic ready;
    logic overlap;
    modport source (output valid, output overlap, input ready);
    modport sink (input valid, input overlap, output ready);
endinterface

// ===== src/tbo_axis_test.sv =====
// One edge-by-box-axis test, registered over three stages.
// The edge has components ea (first of the plane) and eb (second); the
// axis is (-eb, ea) in the plane of components p and q.
module tbo_axis_test #(
    parameter int W = 18
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_ea,
    input  logic signed [W-1:0] i_eb,
    input  logic signed [W-1:0] i_tp [3],
    input  logic signed [W-1:0] i_tq [3],
    input  logic signed [W-1:0] i_lp,
    input  logic signed [W-1:0] i_lq,
    input  logic signed [W-1:0] i_hp,
    input  logic signed [W-1:0] i_hq,
    output logic                o_sep
);
    localparam int P = 2*W + 2;
    logic signed [P-1:0] r_t [3];
    logic signed [P-1:0] r_bl_p, r_bh_p, r_bl_q, r_bh_q;
    logic                r_zero, r_zero2;
    logic signed [P-1:0] r_tmin, r_tmax, r_bmin, r_bmax;

    // Stage one: products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= P'(i_ea * i_tq[i]) - P'(i_eb * i_tp[i]);
            end
            r_bl_p <= -P'(i_eb * i_lp);
            r_bh_p <= -P'(i_eb * i_hp);
            r_bl_q <= P'(i_ea * i_lq);
            r_bh_q <= P'(i_ea * i_hq);
            r_zero <= (i_ea == '0) && (i_eb == '0);
        end
    end

    // Stage two: extremes of both projections.
    logic signed [P-1:0] n_tmin, n_tmax;
    always_comb begin
        n_tmin = r_t[0];
        n_tmax = r_t[0];
        for (int i = 1; i < 3; i++) begin
            if (r_t[i] < n_tmin) n_tmin = r_t[i];
            if (r_t[i] > n_tmax) n_tmax = r_t[i];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tmin  <= n_tmin;
            r_tmax  <= n_tmax;
            r_bmin  <= ((r_bl_p < r_bh_p) ? r_bl_p : r_bh_p)
                     + ((r_bl_q < r_bh_q) ? r_bl_q : r_bh_q);
            r_bmax  <= ((r_bl_p > r_bh_p) ? r_bl_p : r_bh_p)
                     + ((r_bl_q > r_bh_q) ? r_bl_q : r_bh_q);
            r_zero2 <= r_zero;
        end
    end

    // Stage three: touching or apart separates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sep <= !r_zero2 && ((r_bmax <= r_tmin) || (r_bmin >= r_tmax));
        end
    end
endmodule

// ===== src/triangle_box_overlap_test_top.sv =====
// Triangle against axis-aligned box overlap test (separating axes).
// Input channel i_item carries three vertices and the two box corners,
// each point packing signed x, y, z in 16-bit lanes; the low COORD_BITS
// of each lane are used. Output channel o_res carries one overlap bit
// per item, in order.
// The result is offered after four pipeline stages (difference, products,
// extremes and sums, compares) and the output register. Throughput is one
// item per cycle while the output is not stalled.
// The pipeline advances whenever the output register is empty or being
// taken, so a stalled receiver holds every stage in place and nothing is
// lost or repeated. Reset clears the valid bits of all stages; the
// payload registers are left as they are.
// The degenerate edge axis (zero vector) never separates.
module triangle_box_overlap_test_top #(
    parameter int COORD_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tbo_in_if.sink    i_item,
    tbo_out_if.source o_res
);
    import tbo_pkg::*;
    localparam int C = COORD_BITS;
    localparam int E = C + 1;          // edge width
    localparam int AW = E + 1;         // axis test operand width
    localparam int NW = 2*E + 1;       // normal component width
    localparam int PW = NW + C + 3;    // normal projection width

    logic [4:0] r_v;
    logic       en;
    assign en = !r_v[4] || o_res.ready;
    assign i_item.ready = en;

    // Unpack lanes.
    logic signed [C-1:0] pt [5][3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pt[0][k] = i_item.data.vertex_a[LANE_W*k +: C];
            pt[1][k] = i_item.data.vertex_b[LANE_W*k +: C];
            pt[2][k] = i_item.data.vertex_c[LANE_W*k +: C];
            pt[3][k] = i_item.data.box_low_corner[LANE_W*k +: C];
            pt[4][k] = i_item.data.box_high_corner[LANE_W*k +: C];
        end
    end

    // Stage one: registered points and edges.
    logic signed [C-1:0] r_p [5][3];
    logic signed [E-1:0] r_e [3][3];
    logic signed [E-1:0] r_n1 [3], r_n2 [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= pt;
            for (int k = 0; k < 3; k++) begin
                r_e[0][k] <= E'(pt[0][k]) - E'(pt[1][k]);
                r_e[1][k] <= E'(pt[1][k]) - E'(pt[2][k]);
                r_e[2][k] <= E'(pt[2][k]) - E'(pt[0][k]);
                r_n1[k]   <= E'(pt[1][k]) - E'(pt[0][k]);
                r_n2[k]   <= E'(pt[2][k]) - E'(pt[0][k]);
            end
        end
    end

    // Box-axis test: strict separation only.
    logic sep_box;
    always_comb begin
        logic signed [C-1:0] mn, mx;
        sep_box = 1'b0;
        for (int k = 0; k < 3; k++) begin
            mn = r_p[0][k];
            mx = r_p[0][k];
            for (int i = 1; i < 3; i++) begin
                if (r_p[i][k] < mn) mn = r_p[i][k];
                if (r_p[i][k] > mx) mx = r_p[i][k];
            end
            if (mx < r_p[3][k] || mn > r_p[4][k]) sep_box = 1'b1;
        end
    end

    // Stage two: normal cross products.
    logic signed [NW-1:0] r_nm [3];
    logic signed [C-1:0]  r_p2 [5][3];
    logic [1:0]           r_sb;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nm[0] <= NW'(r_n1[1]*r_n2[2]) - NW'(r_n1[2]*r_n2[1]);
            r_nm[1] <= NW'(r_n1[2]*r_n2[0]) - NW'(r_n1[0]*r_n2[2]);
            r_nm[2] <= NW'(r_n1[0]*r_n2[1]) - NW'(r_n1[1]*r_n2[0]);
            r_p2    <= r_p;
            r_sb[0] <= sep_box;
            r_sb[1] <= r_sb[0];
        end
    end

    // Stage three: normal projections of the box corners and vertex.
    logic signed [PW-1:0] r_pl [3], r_ph [3], r_off [3];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pl[k]  <= PW'(r_nm[k] * r_p2[3][k]);
                r_ph[k]  <= PW'(r_nm[k] * r_p2[4][k]);
                r_off[k] <= PW'(r_nm[k] * r_p2[0][k]);
            end
        end
    end

    // Stage four: sums and normal compare.
    logic signed [PW-1:0] bmin, bmax, off;
    always_comb begin
        bmin = '0;
        bmax = '0;
        off  = '0;
        for (int k = 0; k < 3; k++) begin
            bmin += (r_pl[k] < r_ph[k]) ? r_pl[k] : r_ph[k];
            bmax += (r_pl[k] > r_ph[k]) ? r_pl[k] : r_ph[k];
            off  += r_off[k];
        end
    end
    logic r_sep_n, r_sep_b;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sep_n <= (bmax < off) || (bmin > off);
            r_sep_b <= r_sb[1];
        end
    end

    // Edge axes, one for each pairing of an edge with a unit axis, fed from the registered points and edges.
    logic [8:0] sep_e;
    for (genvar i = 0; i < 3; i++) begin : g_edge
        for (genvar j = 0; j < 3; j++) begin : g_axis
            localparam int A = (j + 1) % 3;
            localparam int B = (j + 2) % 3;
            logic signed [AW-1:0] tp [3], tq [3];
            always_comb begin
                for (int v = 0; v < 3; v++) begin
                    tp[v] = AW'(r_p[v][A]);
                    tq[v] = AW'(r_p[v][B]);
                end
            end
            // axis = edge x unit_j: component A gets e[B], B gets -e[A].
            tbo_axis_test #(.W(AW)) u_axis (
                .i_clk (i_clk),
                .i_en  (en),
                .i_ea  (-AW'(r_e[i][A])),
                .i_eb  (-AW'(r_e[i][B])),
                .i_tp  (tp),
                .i_tq  (tq),
                .i_lp  (AW'(r_p[3][A])),
                .i_lq  (AW'(r_p[3][B])),
                .i_hp  (AW'(r_p[4][A])),
                .i_hq  (AW'(r_p[4][B])),
                .o_sep (sep_e[3*i+j])
            );
        end
    end

    // Output register.
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ov <= !(r_sep_n || r_sep_b || (|sep_e));
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], i_item.valid};
        end
    end
    assign o_res.valid   = r_v[4];
    assign o_res.overlap = r_ov;
endmodule
